@@ rtl/rotary_encoder_interface_assert.svh @@
// Assertion helpers for the rotary encoder interface
`ifndef ROTARY_ENCODER_INTERFACE_ASSERT_SVH
`define ROTARY_ENCODER_INTERFACE_ASSERT_SVH

// same-cycle implication
`define REI_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define REI_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/rei_pkg.sv @@
`default_nettype none

package rei_pkg;

    localparam int EDGES_PER_CLICK_DEF = 4;

    localparam int CNT_W  = 32;
    localparam int DIV_W  = 8;
    localparam int TIME_W = 32;
    localparam int DBT_W  = 16;
    localparam int LPT_W  = 16;
    localparam int CFG_W  = 16;
    localparam int IDX_W  = 2;
    localparam int STEP_W = $clog2(CNT_W);

    localparam logic [IDX_W-1:0] CFG_STEPS_PER_ITEM  = 2'd0;
    localparam logic [IDX_W-1:0] CFG_DEBOUNCE_TIME   = 2'd1;
    localparam logic [IDX_W-1:0] CFG_LONG_PRESS_TIME = 2'd2;

    typedef enum logic [1:0] {
        EV_ROTATE = 2'd0,
        EV_SHORT  = 2'd1,
        EV_LONG   = 2'd2
    } event_t;

    // step for {prev_a, prev_b, now_a, now_b}
    localparam logic signed [1:0] STEP_LUT [0:15] = '{
         2'sd0, -2'sd1,  2'sd1,  2'sd0,
         2'sd1,  2'sd0,  2'sd0, -2'sd1,
        -2'sd1,  2'sd0,  2'sd0,  2'sd1,
         2'sd0,  2'sd1, -2'sd1,  2'sd0
    };

endpackage

`default_nettype wire

@@ rtl/rotary_encoder_interface.sv @@
// Pin sample: no result, and the input stays open; the next item can transfer on the next edge.
// Poll: 32 divide steps by the one-bit-per-cycle restoring divider, then 1 sign fix-up
// in ST_FIN, after which the first result, if any, is valid; a poll holds the input
// stalled through the divide and the fix-up even with no result, and further until each
// result transfers, through any output stall.
// Reset (rst_n low, asynchronous) returns all registers to their reset values.
`default_nettype none

module rotary_encoder_interface #(
    parameter int EDGES_PER_CLICK = rei_pkg::EDGES_PER_CLICK_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic                            kind,
    input  wire logic                            pin_a,
    input  wire logic                            pin_b,
    input  wire logic                            switch_level,
    input  wire logic [rei_pkg::TIME_W-1:0]      now_ms,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [1:0]                           event_res,
    output logic signed [rei_pkg::CNT_W-1:0]     rotate_delta,
    output logic                                 last,
    input  wire logic                            cfg_we,
    input  wire logic [rei_pkg::IDX_W-1:0]       cfg_index,
    input  wire logic [rei_pkg::CFG_W-1:0]       cfg_data
);

    localparam int AW = $clog2(EDGES_PER_CLICK + 1) + 1;
    localparam logic signed [AW-1:0] EPD = AW'(EDGES_PER_CLICK);
    localparam int CW = rei_pkg::CNT_W;
    localparam int SW = rei_pkg::STEP_W;
    localparam int DW = rei_pkg::DIV_W;
    localparam logic signed [CW-1:0] CNT_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CNT_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic [SW-1:0] STEP_LAST = {SW{1'b1}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_FIN,
        ST_ROT,
        ST_PRESS
    } state_t;

    state_t                            state_reg, state_next;
    logic [DW-1:0]                     spi_reg, spi_next;
    logic [rei_pkg::DBT_W-1:0]         dbt_reg, dbt_next;
    logic [rei_pkg::LPT_W-1:0]         lpt_reg, lpt_next;
    logic [1:0]                        pins_reg, pins_next;
    logic signed [AW-1:0]              accum_reg, accum_next;
    logic signed [CW-1:0]              detent_reg, detent_next;
    logic                              stable_reg, stable_next;
    logic [rei_pkg::TIME_W-1:0]        change_t_reg, change_t_next;
    logic [rei_pkg::TIME_W-1:0]        press_t_reg, press_t_next;
    logic                              long_fired_reg, long_fired_next;
    logic [SW-1:0]                     step_reg, step_next;
    logic [CW-1:0]                     quo_reg, quo_next;
    logic [DW-1:0]                     rem_reg, rem_next;
    logic [DW-1:0]                     div_reg, div_next;
    logic                              neg_reg, neg_next;
    logic                              pend_reg, pend_next;
    rei_pkg::event_t                   pend_ev_reg, pend_ev_next;
    logic                              out_valid_reg, out_valid_next;
    rei_pkg::event_t                   ev_reg, ev_next;
    logic signed [CW-1:0]              delta_reg, delta_next;
    logic                              last_reg, last_next;

    logic signed [1:0]                 step;
    logic signed [AW-1:0]              acc_sum;
    logic [rei_pkg::TIME_W-1:0]        since_change;
    logic [rei_pkg::TIME_W-1:0]        since_press;
    logic                              sw_change;
    logic                              long_ok;
    logic [DW:0]                       rem_sh;
    logic                              q_bit;

    assign step         = rei_pkg::STEP_LUT[{pins_reg, pin_a, pin_b}];
    assign acc_sum      = accum_reg + AW'(step);
    assign since_change = now_ms - change_t_reg;
    assign since_press  = now_ms - press_t_reg;
    assign sw_change    = (switch_level != stable_reg)
                          && (since_change >= rei_pkg::TIME_W'(dbt_reg));
    assign long_ok      = (sw_change && !switch_level) ? (lpt_reg == '0)
                          : (!long_fired_reg && since_press >= rei_pkg::TIME_W'(lpt_reg));
    assign rem_sh       = {rem_reg, quo_reg[CW-1]};
    assign q_bit        = rem_sh >= {1'b0, div_reg};

    always_comb
    begin
        state_next      = state_reg;
        spi_next        = spi_reg;
        dbt_next        = dbt_reg;
        lpt_next        = lpt_reg;
        pins_next       = pins_reg;
        accum_next      = accum_reg;
        detent_next     = detent_reg;
        stable_next     = stable_reg;
        change_t_next   = change_t_reg;
        press_t_next    = press_t_reg;
        long_fired_next = long_fired_reg;
        step_next       = step_reg;
        quo_next        = quo_reg;
        rem_next        = rem_reg;
        div_next        = div_reg;
        neg_next        = neg_reg;
        pend_next       = pend_reg;
        pend_ev_next    = pend_ev_reg;
        out_valid_next  = out_valid_reg;
        ev_next         = ev_reg;
        delta_next      = delta_reg;
        last_next       = last_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                rei_pkg::CFG_STEPS_PER_ITEM:  spi_next = cfg_data[DW-1:0];
                rei_pkg::CFG_DEBOUNCE_TIME:   dbt_next = cfg_data[rei_pkg::DBT_W-1:0];
                rei_pkg::CFG_LONG_PRESS_TIME: lpt_next = cfg_data[rei_pkg::LPT_W-1:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && !kind)
                begin
                    pins_next = {pin_a, pin_b};
                    if (step != 2'sd0)
                    begin
                        accum_next = acc_sum;
                        if (acc_sum >= EPD)
                        begin
                            accum_next = acc_sum - EPD;
                            if (detent_reg != CNT_MAX)
                                detent_next = detent_reg + CW'(1);
                        end
                        else if (acc_sum <= -EPD)
                        begin
                            accum_next = acc_sum + EPD;
                            if (detent_reg != CNT_MIN)
                                detent_next = detent_reg - CW'(1);
                        end
                    end
                end
                else if (in_valid)
                begin
                    neg_next    = detent_reg[CW-1];
                    quo_next    = detent_reg[CW-1] ? CW'(-detent_reg) : CW'(detent_reg);
                    rem_next    = '0;
                    div_next    = (spi_reg == '0) ? DW'(1) : spi_reg;
                    step_next   = '0;
                    detent_next = '0;
                    pend_next   = 1'b0;
                    if (sw_change)
                    begin
                        change_t_next = now_ms;
                        stable_next   = switch_level;
                        if (!switch_level)
                        begin
                            press_t_next    = now_ms;
                            long_fired_next = 1'b0;
                        end
                        else if (!long_fired_reg)
                        begin
                            pend_next    = 1'b1;
                            pend_ev_next = rei_pkg::EV_SHORT;
                        end
                    end
                    if (!switch_level && long_ok)
                    begin
                        long_fired_next = 1'b1;
                        pend_next       = 1'b1;
                        pend_ev_next    = rei_pkg::EV_LONG;
                    end
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next  = q_bit ? DW'(rem_sh - {1'b0, div_reg}) : rem_sh[DW-1:0];
                quo_next  = {quo_reg[CW-2:0], q_bit};
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_LAST)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (quo_reg != '0)
                begin
                    out_valid_next = 1'b1;
                    ev_next        = rei_pkg::EV_ROTATE;
                    delta_next     = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);
                    last_next      = !pend_reg;
                    state_next     = ST_ROT;
                end
                else if (pend_reg)
                begin
                    out_valid_next = 1'b1;
                    ev_next        = pend_ev_reg;
                    delta_next     = '0;
                    last_next      = 1'b1;
                    state_next     = ST_PRESS;
                end
                else
                    state_next = ST_IDLE;
            end
            ST_ROT:
            begin
                if (!out_stall)
                begin
                    if (pend_reg)
                    begin
                        ev_next    = pend_ev_reg;
                        delta_next = '0;
                        last_next  = 1'b1;
                        state_next = ST_PRESS;
                    end
                    else
                    begin
                        out_valid_next = 1'b0;
                        state_next     = ST_IDLE;
                    end
                end
            end
            ST_PRESS:
            begin
                if (!out_stall)
                begin
                    out_valid_next = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            spi_reg        <= DW'(1);
            dbt_reg        <= rei_pkg::DBT_W'(30);
            lpt_reg        <= rei_pkg::LPT_W'(600);
            pins_reg       <= 2'b11;
            accum_reg      <= '0;
            detent_reg     <= '0;
            stable_reg     <= 1'b1;
            change_t_reg   <= '0;
            press_t_reg    <= '0;
            long_fired_reg <= 1'b0;
            step_reg       <= '0;
            quo_reg        <= '0;
            rem_reg        <= '0;
            div_reg        <= DW'(1);
            neg_reg        <= 1'b0;
            pend_reg       <= 1'b0;
            pend_ev_reg    <= rei_pkg::EV_SHORT;
            out_valid_reg  <= 1'b0;
            ev_reg         <= rei_pkg::EV_ROTATE;
            delta_reg      <= '0;
            last_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            spi_reg        <= spi_next;
            dbt_reg        <= dbt_next;
            lpt_reg        <= lpt_next;
            pins_reg       <= pins_next;
            accum_reg      <= accum_next;
            detent_reg     <= detent_next;
            stable_reg     <= stable_next;
            change_t_reg   <= change_t_next;
            press_t_reg    <= press_t_next;
            long_fired_reg <= long_fired_next;
            step_reg       <= step_next;
            quo_reg        <= quo_next;
            rem_reg        <= rem_next;
            div_reg        <= div_next;
            neg_reg        <= neg_next;
            pend_reg       <= pend_next;
            pend_ev_reg    <= pend_ev_next;
            out_valid_reg  <= out_valid_next;
            ev_reg         <= ev_next;
            delta_reg      <= delta_next;
            last_reg       <= last_next;
        end
    end

    assign in_stall     = (state_reg != ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign event_res    = ev_reg;
    assign rotate_delta = delta_reg;
    assign last         = last_reg;

`include "rotary_encoder_interface_assert.svh"

    `REI_ASSERT_NXT(a_poll_divides, in_valid && !in_stall && kind, state_reg == ST_DIV, "poll did not start division")
    `REI_ASSERT_IMP(a_no_input_while_result, out_valid, in_stall, "input open while result pending")
    `REI_ASSERT_IMP(a_rotate_nonzero, out_valid && event_res == rei_pkg::EV_ROTATE, rotate_delta != '0, "zero rotate event")
    `REI_ASSERT_IMP(a_press_zero_delta, out_valid && event_res != rei_pkg::EV_ROTATE, rotate_delta == '0 && last, "press event malformed")

endmodule

`default_nettype wire

@@ bench/rotary_encoder_interface_test.sv @@
`timescale 1ns / 1ps

module rotary_encoder_interface_test;

    import rei_pkg::*;

    localparam int DETENT_EDGES = 4;
    localparam int LIMIT_CYCLES = 500000;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASE_ITEMS = 180;

    // step for {prev_a, prev_b, now_a, now_b}
    localparam int STEP_TAB [16] = '{
         0, -1,  1,  0,
         1,  0,  0, -1,
        -1,  0,  0,  1,
         0,  1, -1,  0
    };

    typedef struct {
        event_t             ev;
        logic signed [31:0] delta;
        bit                 last_flag;
    } event_rec;

    class encoder_checker;
        logic [1:0]         pins_prev;
        int                 edge_sum;
        logic signed [31:0] detents;
        logic               sw_stable;
        logic [31:0]        sw_change_ms;
        logic [31:0]        press_ms;
        bit                 long_done;
        logic [7:0]         div_reg;
        logic [15:0]        debounce_ms;
        logic [15:0]        long_ms;
        event_rec           expected_events[$];
        int                 errors;

        function new();
            pins_prev = 2'b11;
            edge_sum = 0;
            detents = 0;
            sw_stable = 1'b1;
            sw_change_ms = 0;
            press_ms = 0;
            long_done = 0;
            div_reg = 8'd1;
            debounce_ms = 16'd30;
            long_ms = 16'd600;
            errors = 0;
        endfunction

        function void set_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_STEPS_PER_ITEM:  div_reg = val[7:0];
                CFG_DEBOUNCE_TIME:   debounce_ms = val;
                CFG_LONG_PRESS_TIME: long_ms = val;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_events.size();
        endfunction

        function void push_event(event_t ev, logic signed [31:0] d);
            event_rec e;
            e.ev = ev;
            e.delta = d;
            e.last_flag = 0;
            expected_events.push_back(e);
        endfunction

        function void note_transfer(bit k, bit a, bit b, bit sw, logic [31:0] now);
            int          st;
            int          first;
            longint      q;
            longint      divisor;
            logic [31:0] elapsed;
            event_rec    tail;
            first = expected_events.size();
            if (!k) begin
                st = STEP_TAB[{pins_prev, a, b}];
                pins_prev = {a, b};
                if (st == 0)
                    return;
                edge_sum += st;
                if (edge_sum >= DETENT_EDGES) begin
                    edge_sum -= DETENT_EDGES;
                    if (detents != 32'sh7fff_ffff)
                        detents = detents + 1;
                end
                else if (edge_sum <= -DETENT_EDGES) begin
                    edge_sum += DETENT_EDGES;
                    if (detents != 32'sh8000_0000)
                        detents = detents - 1;
                end
                return;
            end
            divisor = (div_reg == 8'd0) ? 64'sd1 : longint'(div_reg);
            q = longint'(detents) / divisor;
            detents = 0;
            if (q != 0)
                push_event(EV_ROTATE, q[31:0]);
            elapsed = now - sw_change_ms;
            if (sw != sw_stable && elapsed >= {16'd0, debounce_ms}) begin
                sw_change_ms = now;
                sw_stable = sw;
                if (!sw) begin
                    press_ms = now;
                    long_done = 0;
                end
                else if (!long_done)
                    push_event(EV_SHORT, 0);
            end
            elapsed = now - press_ms;
            if (!sw && !long_done && elapsed >= {16'd0, long_ms}) begin
                long_done = 1;
                push_event(EV_LONG, 0);
            end
            if (expected_events.size() > first) begin
                tail = expected_events.pop_back();
                tail.last_flag = 1;
                expected_events.push_back(tail);
            end
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_event(logic [1:0] ev, logic signed [31:0] d, logic lst);
            event_rec e;
            if (expected_events.size() == 0) begin
                report($sformatf("unexpected result event=%0d delta=%0d", ev, d));
                return;
            end
            e = expected_events.pop_front();
            if (ev !== e.ev)
                report($sformatf("event %0d, wanted %0d", ev, e.ev));
            if (d !== e.delta)
                report($sformatf("delta %0d, wanted %0d", d, e.delta));
            if (lst !== e.last_flag)
                report($sformatf("last %0b, wanted %0b", lst, e.last_flag));
        endtask
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic               kind;
    logic               pin_a;
    logic               pin_b;
    logic               switch_level;
    logic [TIME_W-1:0]  now_ms;
    logic               out_valid;
    logic               out_stall;
    logic [1:0]         event_res;
    logic signed [CNT_W-1:0] rotate_delta;
    logic               last;
    logic               cfg_we;
    logic [IDX_W-1:0]   cfg_index;
    logic [CFG_W-1:0]   cfg_data;

    encoder_checker tracker;
    bit             hold_req;
    bit             calm;
    int             cycle_count;
    logic [1:0]     cur_pins;
    logic [31:0]    clock_ms;
    bit             btn;

    rotary_encoder_interface uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .pin_a        (pin_a),
        .pin_b        (pin_b),
        .switch_level (switch_level),
        .now_ms       (now_ms),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .event_res    (event_res),
        .rotate_delta (rotate_delta),
        .last         (last),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                tracker.note_transfer(kind, pin_a, pin_b, switch_level, now_ms);
            if (out_valid && !out_stall)
                tracker.check_event(event_res, rotate_delta, last);
        end
    end

    // receiver: random stall bursts, one long hold-off on request
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 0;
                out_stall <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(negedge clk);
                out_stall <= 1'b0;
            end
            else
                out_stall <= 1'b0;
        end
    end

    task send_item(bit k, bit a, bit b, bit sw, logic [31:0] now);
        if (!calm && $urandom_range(0, 9) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        pin_a <= a;
        pin_b <= b;
        switch_level <= sw;
        now_ms <= now;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task send_pins(logic [1:0] p);
        send_item(1'b0, p[1], p[0], 1'($urandom_range(0, 1)), $urandom());
        cur_pins = p;
    endtask

    task send_poll(bit sw, logic [31:0] now);
        send_item(1'b1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), sw, now);
    endtask

    function logic [1:0] gray_next(logic [1:0] p, bit fwd);
        case (p)
            2'b11:   return fwd ? 2'b01 : 2'b10;
            2'b01:   return fwd ? 2'b00 : 2'b11;
            2'b00:   return fwd ? 2'b10 : 2'b01;
            default: return fwd ? 2'b11 : 2'b00;
        endcase
    endfunction

    task settle();
        in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task write_regs(logic [7:0] steps, logic [15:0] deb, logic [15:0] hold_ms);
        cfg_we <= 1'b1;
        cfg_index <= CFG_STEPS_PER_ITEM;
        cfg_data <= {8'd0, steps};
        @(negedge clk);
        cfg_index <= CFG_DEBOUNCE_TIME;
        cfg_data <= deb;
        @(negedge clk);
        cfg_index <= CFG_LONG_PRESS_TIME;
        cfg_data <= hold_ms;
        @(negedge clk);
        cfg_we <= 1'b0;
        tracker.set_reg(CFG_STEPS_PER_ITEM, {8'd0, steps});
        tracker.set_reg(CFG_DEBOUNCE_TIME, deb);
        tracker.set_reg(CFG_LONG_PRESS_TIME, hold_ms);
    endtask

    task random_poll();
        int r;
        bit lvl;
        r = $urandom_range(0, 99);
        if (r < 3)
            clock_ms = $urandom();
        else if (r < 15)
            clock_ms = clock_ms + $urandom_range(0, 2000);
        else
            clock_ms = clock_ms + $urandom_range(0, 40);
        if ($urandom_range(0, 11) == 0)
            btn = !btn;
        // occasional contact bounce
        lvl = ($urandom_range(0, 11) == 0) ? !btn : btn;
        send_poll(lvl, clock_ms);
    endtask

    task run_phase(int n);
        int  done;
        int  len;
        int  r;
        bit  fwd;
        done = 0;
        while (done < n)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
            begin
                len = $urandom_range(1, 12);
                fwd = 1'($urandom_range(0, 1));
                repeat (len)
                begin
                    if ($urandom_range(0, 6) == 0)
                        fwd = !fwd;
                    send_pins(gray_next(cur_pins, fwd));
                    done++;
                end
            end
            else if (r < 55)
            begin
                send_pins(2'($urandom_range(0, 3)));
                done++;
            end
            else
            begin
                random_poll();
                done++;
            end
        end
    endtask

    initial
    begin
        tracker = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        kind = 1'b0;
        pin_a = 1'b1;
        pin_b = 1'b1;
        switch_level = 1'b1;
        now_ms = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_STEPS_PER_ITEM;
        cfg_data = '0;
        hold_req = 0;
        calm = 0;
        cycle_count = 0;
        cur_pins = 2'b11;
        btn = 1'b1;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed part at reset settings
        send_poll(1'b1, 32'd0);
        send_pins(2'b01);
        send_pins(2'b00);
        send_pins(2'b10);
        send_pins(2'b11);
        send_pins(2'b00);             // impossible transition, ignored
        send_pins(2'b00);             // no change
        send_poll(1'b0, 32'd100);     // rotate +1, press starts
        send_poll(1'b1, 32'd110);     // bounce inside debounce window
        send_poll(1'b0, 32'd700);     // long press on hold threshold
        send_poll(1'b1, 32'd800);     // release after long press: no short
        send_pins(2'b01);
        send_pins(2'b11);
        send_pins(2'b10);
        send_pins(2'b00);
        send_poll(1'b0, 32'd900);     // rotate -1, press starts
        send_pins(2'b10);
        send_pins(2'b11);
        send_pins(2'b01);
        send_pins(2'b00);
        send_poll(1'b1, 32'd950);     // rotate then short press
        send_poll(1'b0, 32'hffff_ffff);
        send_poll(1'b0, 32'h0000_0258); // long press across time wrap
        send_poll(1'b1, 32'h0000_0260);
        settle();

        // zero divisor behaves as one
        write_regs(8'd0, 16'd30, 16'd600);
        send_pins(2'b10);
        send_pins(2'b11);
        send_pins(2'b01);
        send_pins(2'b00);
        send_poll(1'b1, 32'h0000_1000);

        clock_ms = $urandom();
        for (int ph = 0; ph < 6; ph++)
        begin
            settle();
            case (ph)
                0: write_regs(8'd2, 16'd10, 16'd100);
                1: write_regs(8'd1, 16'd0, 16'd0);
                2: write_regs(8'd255, 16'hffff, 16'hffff);
                3: write_regs(8'd3, 16'($urandom_range(0, 40)),
                              16'($urandom_range(50, 300)));
                4: write_regs(8'($urandom_range(1, 255)), 16'($urandom()),
                              16'($urandom()));
                default: write_regs(8'd4, 16'd5, 16'd200);
            endcase
            if (ph == 3)
                hold_req = 1;
            if (ph == 5)
                calm = 1;
            run_phase(PHASE_ITEMS);
        end

        in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (tracker.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ rotary_encoder_interface.f @@
+incdir+rtl
rtl/rei_pkg.sv
rtl/rotary_encoder_interface.sv
bench/rotary_encoder_interface_test.sv
